>>> rtl/core/dbd_pkg.sv
// dbd_pkg: widths, register codes, reset values and shared types of the
// detection box decoder. No dependencies; every other file uses it.
`timescale 1ns / 1ps

package dbd_pkg;

	localparam int VAL_W      = 25;   // signed Q12.12 row element
	localparam int CLS_W      = 8;
	localparam int POS_W      = 9;
	localparam int PIX_W      = 13;
	localparam int EXT_W      = 14;
	localparam int SCALE_W    = 24;   // unsigned Q8.16
	localparam int THR_W      = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	localparam int MAX_CLASSES = 255;
	localparam int BOX_FIELDS  = 4;
	localparam int BOX_IDX_W   = 2;

	// Fixed point shifts: corners carry an extra factor two (2x - w).
	localparam int CORNER_SH = 29;
	localparam int EXTENT_SH = 28;
	localparam int EXT_MAX   = 8191;
	localparam int EXT_MIN   = -8192;

	// Product widths: (2x - w) is VAL_W+2 bits, scale gets a zero sign bit.
	localparam int DIF_W = VAL_W + 2;
	localparam int PC_W  = DIF_W + SCALE_W + 1;
	localparam int PE_W  = VAL_W + SCALE_W + 1;
	localparam int LIM_W = PIX_W + 2;

	localparam logic [CFG_IDX_W-1:0] REG_CLASS_COUNT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCORE_THRESH = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd5;

	localparam logic [CLS_W-1:0]   RST_CLASS_COUNT  = 8'd80;
	localparam logic [THR_W-1:0]   RST_SCORE_THRESH = 13'd1024;
	localparam logic [SCALE_W-1:0] RST_SCALE        = 24'd65536;
	localparam logic [PIX_W-1:0]   RST_IMAGE_DIM    = 13'd640;

	typedef logic signed [VAL_W-1:0] val_t;

	localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

	typedef struct packed {
		logic [CLS_W-1:0]   class_count;
		logic [THR_W-1:0]   score_threshold;
		logic [SCALE_W-1:0] scale_x;
		logic [SCALE_W-1:0] scale_y;
		logic [PIX_W-1:0]   image_width;
		logic [PIX_W-1:0]   image_height;
	} cfg_t;

	// Everything the scaling stages need from a finished row.
	typedef struct packed {
		logic [CLS_W-1:0] best_class;
		val_t             best_score;
		val_t             box_x;
		val_t             box_y;
		val_t             box_w;
		val_t             box_h;
	} row_snap_t;

endpackage

>>> rtl/core/dbd_ifs.sv
// dbd_ifs: valid/ready channel interfaces for row elements and detections.
// Depends on dbd_pkg for field widths.
`timescale 1ns / 1ps

interface dbd_row_if;
	logic                              valid;
	logic                              ready;
	logic signed [dbd_pkg::VAL_W-1:0]  row_value;
	logic                              row_end;

	modport source (output valid, output row_value, output row_end, input ready);
	modport sink   (input valid, input row_value, input row_end, output ready);
endinterface

interface dbd_det_if;
	logic                              valid;
	logic                              ready;
	logic [dbd_pkg::CLS_W-1:0]         class_index;
	logic signed [dbd_pkg::VAL_W-1:0]  confidence;
	logic [dbd_pkg::PIX_W-1:0]         box_left;
	logic [dbd_pkg::PIX_W-1:0]         box_top;
	logic signed [dbd_pkg::EXT_W-1:0]  box_width;
	logic signed [dbd_pkg::EXT_W-1:0]  box_height;

	modport source (output valid, output class_index, output confidence, output box_left,
		output box_top, output box_width, output box_height, input ready);
	modport sink   (input valid, input class_index, input confidence, input box_left,
		input box_top, input box_width, input box_height, output ready);
endinterface

>>> rtl/core/detection_box_decoder.sv
// detection_box_decoder: top level; configuration registers, row tracking
// and box scaling. Uses dbd_pkg, dbd_ifs, dbd_row_track, dbd_box_scale.
//
//  channel   dir  request payload
//  row_in    in   row_value (s25 Q12.12), row_end
//  det_out   out  class_index, confidence, box_left, box_top, box_width, box_height
//  cfg_*     in   cfg_index selects register, cfg_data written on cfg_we
//
// One row element per cycle while row_in.ready is high. A detection follows the
// row-end element through the snapshot, scale multiply, and clamp and output registers.
// Reset restores the register defaults and clears row state at once.
// A held output backs up the two internal stages; row_in.ready drops only
// when a row-end snapshot cannot move on.
`timescale 1ns / 1ps

module detection_box_decoder (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [dbd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [dbd_pkg::CFG_DATA_W-1:0]     cfg_data,
	dbd_row_if.sink                            row_in,
	dbd_det_if.source                          det_out
);
	import dbd_pkg::*;

	cfg_t      cfg_q;
	logic      in_accept;
	logic      take;
	logic      snap_valid_s1;
	row_snap_t snap_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.class_count     <= RST_CLASS_COUNT;
			cfg_q.score_threshold <= RST_SCORE_THRESH;
			cfg_q.scale_x         <= RST_SCALE;
			cfg_q.scale_y         <= RST_SCALE;
			cfg_q.image_width     <= RST_IMAGE_DIM;
			cfg_q.image_height    <= RST_IMAGE_DIM;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CLASS_COUNT:  cfg_q.class_count     <= cfg_data[CLS_W-1:0];
				REG_SCORE_THRESH: cfg_q.score_threshold <= cfg_data[THR_W-1:0];
				REG_SCALE_X:      cfg_q.scale_x         <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Y:      cfg_q.scale_y         <= cfg_data[SCALE_W-1:0];
				REG_IMAGE_WIDTH:  cfg_q.image_width     <= cfg_data[PIX_W-1:0];
				REG_IMAGE_HEIGHT: cfg_q.image_height    <= cfg_data[PIX_W-1:0];
				default: ;
			endcase
		end
	end

	assign row_in.ready = !snap_valid_s1 || take;
	assign in_accept    = row_in.valid && row_in.ready;

	dbd_row_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_accept    (in_accept),
		.row_value    (row_in.row_value),
		.row_end      (row_in.row_end),
		.cfg          (cfg_q),
		.take         (take),
		.snap_valid_s1(snap_valid_s1),
		.snap_s1      (snap_s1)
	);

	dbd_box_scale u_scale (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.snap_valid_s1(snap_valid_s1),
		.snap_s1      (snap_s1),
		.take         (take),
		.det_out      (det_out)
	);

	// width never runs past the right image edge
	a_width_cap: assert property (@(posedge clk) disable iff (!arst_n)
		det_out.valid |-> det_out.box_width
			<= $signed({2'b00, cfg_q.image_width}) - $signed({2'b00, det_out.box_left}))
		else $error("box_width exceeds remaining image width");

	// only rows whose best score beats the threshold come out
	a_conf_above: assert property (@(posedge clk) disable iff (!arst_n)
		det_out.valid |-> det_out.confidence
			> $signed({{(VAL_W-THR_W){1'b0}}, cfg_q.score_threshold}))
		else $error("detection at or below score threshold");

	// a blocked snapshot is neither dropped nor altered
	a_snap_hold: assert property (@(posedge clk) disable iff (!arst_n)
		snap_valid_s1 && !take |=> snap_valid_s1 && $stable(snap_s1))
		else $error("stage 1 snapshot lost while stalled");

endmodule

>>> rtl/core/dbd_row_track.sv
// dbd_row_track: row position, box field capture and running arg-max over
// class scores; snapshots a qualifying row into stage 1. Uses dbd_pkg.
`timescale 1ns / 1ps

module dbd_row_track (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_accept,
	input  dbd_pkg::val_t      row_value,
	input  logic               row_end,
	input  dbd_pkg::cfg_t      cfg,
	input  logic               take,
	output logic               snap_valid_s1,
	output dbd_pkg::row_snap_t snap_s1
);
	import dbd_pkg::*;

	logic [POS_W-1:0] pos_q;
	val_t             box_q [BOX_FIELDS];
	val_t             best_q;
	logic [CLS_W-1:0] class_q;

	logic [CLS_W-1:0] limit;
	logic [POS_W-1:0] cls_pos;
	logic             is_box;
	logic             counted;
	logic             better;
	logic             emit;
	val_t             best_nx;
	logic [CLS_W-1:0] class_nx;
	val_t             box_nx [BOX_FIELDS];

	always_comb begin
		limit    = (int'(cfg.class_count) < MAX_CLASSES) ? cfg.class_count
			: CLS_W'(MAX_CLASSES);
		is_box   = pos_q < POS_W'(BOX_FIELDS);
		cls_pos  = pos_q - POS_W'(BOX_FIELDS);
		counted  = !is_box && (cls_pos < {{(POS_W-CLS_W){1'b0}}, limit});
		// strict compare keeps the first maximum on ties
		better   = counted && (row_value > best_q);
		best_nx  = better ? row_value : best_q;
		class_nx = better ? cls_pos[CLS_W-1:0] : class_q;
		for (int i = 0; i < BOX_FIELDS; i++) begin
			box_nx[i] = (is_box && pos_q[BOX_IDX_W-1:0] == BOX_IDX_W'(i))
				? row_value : box_q[i];
		end
		emit = row_end
			&& (best_nx > $signed({{(VAL_W-THR_W){1'b0}}, cfg.score_threshold}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			best_q  <= VAL_MIN;
			class_q <= '0;
			for (int i = 0; i < BOX_FIELDS; i++) begin
				box_q[i] <= '0;
			end
		end else if (in_accept) begin
			for (int i = 0; i < BOX_FIELDS; i++) begin
				box_q[i] <= box_nx[i];
			end
			if (row_end) begin
				pos_q   <= '0;
				best_q  <= VAL_MIN;
				class_q <= '0;
			end else begin
				if (pos_q != '1) begin
					pos_q <= pos_q + 1'b1;
				end
				best_q  <= best_nx;
				class_q <= class_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_valid_s1 <= 1'b0;
		end else if (in_accept) begin
			snap_valid_s1 <= emit;
		end else if (take) begin
			snap_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept && emit) begin
			snap_s1.best_class <= class_nx;
			snap_s1.best_score <= best_nx;
			snap_s1.box_x      <= box_nx[0];
			snap_s1.box_y      <= box_nx[1];
			snap_s1.box_w      <= box_nx[2];
			snap_s1.box_h      <= box_nx[3];
		end
	end

endmodule

>>> rtl/core/dbd_box_scale.sv
// dbd_box_scale: stage 2 multiplies the box by the scale factors, stage 3
// clamps, caps and registers the detection. Uses dbd_pkg and dbd_det_if.
`timescale 1ns / 1ps

module dbd_box_scale (
	input  logic               clk,
	input  logic               arst_n,
	input  dbd_pkg::cfg_t      cfg,
	input  logic               snap_valid_s1,
	input  dbd_pkg::row_snap_t snap_s1,
	output logic               take,
	dbd_det_if.source          det_out
);
	import dbd_pkg::*;

	function automatic logic [PIX_W-1:0] corner(input logic signed [PC_W-1:0] p);
		logic signed [PC_W-1:0] q;
		q = p >>> CORNER_SH;
		if (p <= 0) begin
			return '0;
		end
		if (|q[PC_W-1:PIX_W]) begin
			return '1;
		end
		return q[PIX_W-1:0];
	endfunction

	function automatic logic [EXT_W-1:0] extent(input logic signed [PE_W-1:0] p,
		input logic signed [LIM_W-1:0] lim);
		logic signed [PE_W-1:0] q;
		// add 2^28-1 before the shift so negatives truncate toward zero
		q = p[PE_W-1] ? ((p + $signed(PE_W'((1 << EXTENT_SH) - 1))) >>> EXTENT_SH)
			: (p >>> EXTENT_SH);
		if (q > PE_W'(lim)) begin
			q = PE_W'(lim);
		end
		if (q > $signed(PE_W'(EXT_MAX))) begin
			q = PE_W'(EXT_MAX);
		end
		if (q < $signed(PE_W'(EXT_MIN))) begin
			q = PE_W'(EXT_MIN);
		end
		return q[EXT_W-1:0];
	endfunction

	logic                    valid_s2;
	logic [CLS_W-1:0]        class_s2;
	val_t                    score_s2;
	logic signed [PC_W-1:0]  prod_l_s2;
	logic signed [PC_W-1:0]  prod_t_s2;
	logic signed [PE_W-1:0]  prod_w_s2;
	logic signed [PE_W-1:0]  prod_h_s2;

	logic                    out_valid_q;
	logic [CLS_W-1:0]        class_q;
	val_t                    conf_q;
	logic [PIX_W-1:0]        left_q;
	logic [PIX_W-1:0]        top_q;
	logic [EXT_W-1:0]        width_q;
	logic [EXT_W-1:0]        height_q;

	logic                    out_adv;
	logic signed [DIF_W-1:0] dx;
	logic signed [DIF_W-1:0] dy;
	logic [PIX_W-1:0]        left;
	logic [PIX_W-1:0]        top;
	logic signed [LIM_W-1:0] lim_w;
	logic signed [LIM_W-1:0] lim_h;

	assign out_adv = !out_valid_q || det_out.ready;
	assign take    = !valid_s2 || out_adv;

	always_comb begin
		dx = {snap_s1.box_x[VAL_W-1], snap_s1.box_x, 1'b0}
			- {{2{snap_s1.box_w[VAL_W-1]}}, snap_s1.box_w};
		dy = {snap_s1.box_y[VAL_W-1], snap_s1.box_y, 1'b0}
			- {{2{snap_s1.box_h[VAL_W-1]}}, snap_s1.box_h};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (take) begin
			valid_s2 <= snap_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (take && snap_valid_s1) begin
			class_s2  <= snap_s1.best_class;
			score_s2  <= snap_s1.best_score;
			prod_l_s2 <= dx * $signed({1'b0, cfg.scale_x});
			prod_t_s2 <= dy * $signed({1'b0, cfg.scale_y});
			prod_w_s2 <= snap_s1.box_w * $signed({1'b0, cfg.scale_x});
			prod_h_s2 <= snap_s1.box_h * $signed({1'b0, cfg.scale_y});
		end
	end

	always_comb begin
		left  = corner(prod_l_s2);
		top   = corner(prod_t_s2);
		lim_w = $signed({2'b00, cfg.image_width}) - $signed({2'b00, left});
		lim_h = $signed({2'b00, cfg.image_height}) - $signed({2'b00, top});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_adv && valid_s2) begin
			class_q  <= class_s2;
			conf_q   <= score_s2;
			left_q   <= left;
			top_q    <= top;
			width_q  <= extent(prod_w_s2, lim_w);
			height_q <= extent(prod_h_s2, lim_h);
		end
	end

	assign det_out.valid       = out_valid_q;
	assign det_out.class_index = class_q;
	assign det_out.confidence  = conf_q;
	assign det_out.box_left    = left_q;
	assign det_out.box_top     = top_q;
	assign det_out.box_width   = $signed(width_q);
	assign det_out.box_height  = $signed(height_q);

endmodule
